// File: rtl/multi_stage_echo_delay_unit_assert.svh
// Assertion macros shared by the echo delay unit
`ifndef MULTI_STAGE_ECHO_DELAY_UNIT_ASSERT_SVH
`define MULTI_STAGE_ECHO_DELAY_UNIT_ASSERT_SVH

// same-cycle implication
`define MSED_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define MSED_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/msed_pkg.sv
// Types, constants and codes of the multi-stage echo delay unit
`timescale 1ns / 1ps
package msed_pkg;

   localparam int SAMPLE_BITS    = 24;
   localparam int CHANNELS_DEF   = 2;
   localparam int MAX_STAGES_DEF = 10;
   localparam int MAX_LINE_DEF   = 4096;

   localparam int GAIN_W      = 17;
   localparam int OGAIN_W     = 19;
   localparam int LEN_FIELD_W = 13;
   localparam int SEL_W       = 4;
   localparam int ACT_W       = 4;
   localparam int CSR_IDX_W   = 4;
   localparam int CSR_DATA_W  = 19;

   localparam int DRY_W = SAMPLE_BITS + GAIN_W + 1;
   localparam int ACC_W = DRY_W + 4;
   localparam int SCL_W = SAMPLE_BITS + OGAIN_W + 1;

   localparam logic [GAIN_W-1:0]  UNITY_Q16    = 17'd65536;
   localparam logic [OGAIN_W-1:0] OUT_GAIN_MAX = 19'd327680;

   localparam logic OP_AUDIO = 1'b0;
   localparam logic OP_LOAD  = 1'b1;

   localparam logic [CSR_IDX_W-1:0] CSR_SEQ_MODE = 4'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ACTIVE   = 4'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_IN_GAIN  = 4'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_OUT_GAIN = 4'd3;

   typedef struct packed {
      logic                          op;
      logic                          chan;
      logic signed [SAMPLE_BITS-1:0] sample_in;
      logic [SEL_W-1:0]              stage_sel;
      logic [LEN_FIELD_W-1:0]        line_length;
      logic [GAIN_W-1:0]             decay_factor;
   } msed_req_type;

   typedef struct packed {
      logic                          out_chan;
      logic signed [SAMPLE_BITS-1:0] sample_out;
   } msed_rsp_type;

   typedef struct packed {
      logic               seq_mode;
      logic [GAIN_W-1:0]  in_gain;
      logic [OGAIN_W-1:0] out_gain;
   } msed_cfg_type;

   typedef struct packed {
      logic              valid;
      logic              first;
      logic              last;
      logic              zero_len;
      logic              hit;
      logic [GAIN_W-1:0] decay;
   } msed_stage_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ISSUE,
      ST_WAIT
   } msed_state_type;

endpackage

// File: rtl/multi_stage_echo_delay_unit.sv
// Top level of the multi-stage echo delay unit
//
// req_* carries audio beats (op audio) and stage loads (op load); rsp_* returns one
// result beat per audio beat on a channel in range, none for a load.
// csr_* writes mode, stage count and gains; writes are taken only while idle.
// A load is written into the stage table and leaves the unit idle. An audio beat
// is taken only while idle; the next one waits until the previous result has
// entered the result register. Each stage of nonzero length reads and writes the
// delay memory once (one read port, one write port), one stage a cycle; then come
// a three-stage multiply and accumulate, a rounding step and an output gain step.
// Reset returns control registers and stage settings to their defaults and clears
// every line pointer and fill count at once; an entry not yet written since reset
// reads as zero, so no clearing pass over the memory is needed.
// While rsp_stall is high the result beat holds; one further audio beat is worked
// through and held in the last gain stage, after which req_stall stays high.
`timescale 1ns / 1ps
`include "multi_stage_echo_delay_unit_assert.svh"
module multi_stage_echo_delay_unit #(
   parameter int CHANNELS   = msed_pkg::CHANNELS_DEF,
   parameter int MAX_STAGES = msed_pkg::MAX_STAGES_DEF,
   parameter int MAX_LINE   = msed_pkg::MAX_LINE_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  msed_pkg::msed_req_type               req_data,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output msed_pkg::msed_rsp_type               rsp_data,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [msed_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [msed_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   localparam int LINES  = CHANNELS * MAX_STAGES;
   localparam int LINE_W = (LINES > 1) ? $clog2(LINES) : 1;
   localparam int STG_W  = (MAX_STAGES > 1) ? $clog2(MAX_STAGES) : 1;
   localparam int PTR_W  = $clog2(MAX_LINE);
   localparam int AW     = LINE_W + PTR_W;
   localparam int DEPTH  = LINES * (2 ** PTR_W);

   msed_pkg::msed_cfg_type   cfg_ff;
   logic [STG_W-1:0]         last_stage_ff;

   logic                     start;
   logic                     done;
   logic                     idle;
   logic                     mem_re;
   logic                     mem_we;
   logic [AW-1:0]            mem_raddr;
   logic [AW-1:0]            mem_waddr;
   logic signed [msed_pkg::SAMPLE_BITS-1:0] mem_rdata;
   logic signed [msed_pkg::SAMPLE_BITS-1:0] mem_wdata;
   msed_pkg::msed_stage_type stage;

   logic [msed_pkg::ACT_W-1:0]   act;
   logic [msed_pkg::GAIN_W-1:0]  in_gain;
   logic [msed_pkg::OGAIN_W-1:0] out_gain;
   logic [STG_W-1:0]             last_stage;

   assign csr_ready = idle;

   always_comb begin
      act      = csr_wdata[msed_pkg::ACT_W-1:0];
      in_gain  = csr_wdata[msed_pkg::GAIN_W-1:0];
      out_gain = csr_wdata[msed_pkg::OGAIN_W-1:0];
      if (act == '0) begin
         last_stage = '0;
      end else if (int'(act) > MAX_STAGES) begin
         last_stage = STG_W'(MAX_STAGES - 1);
      end else begin
         last_stage = STG_W'(act - msed_pkg::ACT_W'(1));
      end
      if (in_gain > msed_pkg::UNITY_Q16) begin
         in_gain = msed_pkg::UNITY_Q16;
      end
      if (out_gain > msed_pkg::OUT_GAIN_MAX) begin
         out_gain = msed_pkg::OUT_GAIN_MAX;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff        <= '{seq_mode: 1'b0, in_gain: '0, out_gain: '0};
         last_stage_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            msed_pkg::CSR_SEQ_MODE: begin
               cfg_ff.seq_mode <= csr_wdata[0];
            end
            msed_pkg::CSR_ACTIVE: begin
               last_stage_ff <= last_stage;
            end
            msed_pkg::CSR_IN_GAIN: begin
               cfg_ff.in_gain <= in_gain;
            end
            msed_pkg::CSR_OUT_GAIN: begin
               cfg_ff.out_gain <= out_gain;
            end
            default: begin
            end
         endcase
      end
   end

   msed_seq #(
      .CHANNELS   (CHANNELS),
      .MAX_STAGES (MAX_STAGES),
      .MAX_LINE   (MAX_LINE)
   ) u_seq (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_data   (req_data),
      .req_stall  (req_stall),
      .last_stage (last_stage_ff),
      .done       (done),
      .start      (start),
      .idle       (idle),
      .rd_en      (mem_re),
      .rd_addr    (mem_raddr),
      .wr_addr    (mem_waddr),
      .stage      (stage)
   );

   msed_store #(
      .DEPTH (DEPTH),
      .AW    (AW)
   ) u_store (
      .clock   (clock),
      .rd_en   (mem_re),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata)
   );

   msed_dsp u_dsp (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .sample    (req_data.sample_in),
      .chan      (req_data.chan),
      .cfg       (cfg_ff),
      .stage     (stage),
      .rd_data   (mem_rdata),
      .wr_en     (mem_we),
      .wr_data   (mem_wdata),
      .done      (done),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   `MSED_ASSERT_NEXT(a_audio_holds_input, clock, reset, start, req_stall, "audio beat not followed by input stall")
   `MSED_ASSERT_NOW(a_result_while_busy, clock, reset, done, !idle, "result loaded while sequencer idle")
   `MSED_ASSERT_NOW(a_write_after_read, clock, reset, mem_we, mem_waddr == $past(mem_raddr), "delay write address differs from preceding read")

endmodule

// File: rtl/msed_store.sv
// Delay line memory: one write port, one read port with registered data
`timescale 1ns / 1ps
module msed_store #(
   parameter int DEPTH = 81920,
   parameter int AW    = 17
) (
   input  logic                                    clock,
   input  logic                                    rd_en,
   input  logic [AW-1:0]                           rd_addr,
   output logic signed [msed_pkg::SAMPLE_BITS-1:0] rd_data,
   input  logic                                    wr_en,
   input  logic [AW-1:0]                           wr_addr,
   input  logic signed [msed_pkg::SAMPLE_BITS-1:0] wr_data
);

   logic signed [msed_pkg::SAMPLE_BITS-1:0] store_ff [DEPTH];
   logic signed [msed_pkg::SAMPLE_BITS-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= store_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/msed_seq.sv
// Stage sequencer: state machine, stage table, line pointers and fill counts
`timescale 1ns / 1ps
module msed_seq #(
   parameter int CHANNELS   = msed_pkg::CHANNELS_DEF,
   parameter int MAX_STAGES = msed_pkg::MAX_STAGES_DEF,
   parameter int MAX_LINE   = msed_pkg::MAX_LINE_DEF,
   localparam int LINES  = CHANNELS * MAX_STAGES,
   localparam int LINE_W = (LINES > 1) ? $clog2(LINES) : 1,
   localparam int STG_W  = (MAX_STAGES > 1) ? $clog2(MAX_STAGES) : 1,
   localparam int PTR_W  = $clog2(MAX_LINE),
   localparam int LEN_W  = $clog2(MAX_LINE + 1),
   localparam int AW     = LINE_W + PTR_W
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   input  msed_pkg::msed_req_type   req_data,
   output logic                     req_stall,
   input  logic [STG_W-1:0]         last_stage,
   input  logic                     done,
   output logic                     start,
   output logic                     idle,
   output logic                     rd_en,
   output logic [AW-1:0]            rd_addr,
   output logic [AW-1:0]            wr_addr,
   output msed_pkg::msed_stage_type stage
);

   msed_pkg::msed_state_type state_ff, state_in;

   logic [LINE_W-1:0]               line_ff;
   logic [STG_W-1:0]                stg_ff;
   logic [STG_W-1:0]                last_ff;
   logic [PTR_W-1:0]                ptr_ff  [LINES];
   logic [LEN_W-1:0]                fill_ff [LINES];
   logic [LEN_W-1:0]                len_ff  [MAX_STAGES];
   logic [msed_pkg::GAIN_W-1:0]     dec_ff  [MAX_STAGES];
   logic                            p1_v_ff;
   msed_pkg::msed_stage_type        p1_ff;
   logic [AW-1:0]                   wr_addr_ff;

   logic                            accept;
   logic                            chan_ok;
   logic                            load;
   logic                            issue;
   logic [STG_W-1:0]                sel_idx;
   logic [LEN_W-1:0]                len_clamp;
   logic [msed_pkg::GAIN_W-1:0]     dec_clamp;
   logic [LINE_W-1:0]               line_base;
   logic [LEN_W-1:0]                cur_len;
   logic [PTR_W-1:0]                raw_ptr;
   logic [PTR_W-1:0]                cur_ptr;
   logic [LEN_W-1:0]                fill;
   logic [LEN_W-1:0]                ptr_inc;
   logic                            zero_len;
   logic                            hit;
   logic                            wrap;

   always_comb begin
      req_stall = (state_ff != msed_pkg::ST_IDLE);
      idle      = (state_ff == msed_pkg::ST_IDLE);
      accept    = req_valid && !req_stall;
      chan_ok   = (CHANNELS > 1) || !req_data.chan;
      start     = accept && (req_data.op == msed_pkg::OP_AUDIO) && chan_ok;
      load      = accept && (req_data.op == msed_pkg::OP_LOAD)
                  && (int'(req_data.stage_sel) < MAX_STAGES);
      issue     = 1'b0;
      state_in  = state_ff;
      case (state_ff)
         msed_pkg::ST_IDLE: begin
            if (start) begin
               state_in = msed_pkg::ST_ISSUE;
            end
         end
         msed_pkg::ST_ISSUE: begin
            issue = 1'b1;
            if (stg_ff == last_ff) begin
               state_in = msed_pkg::ST_WAIT;
            end
         end
         msed_pkg::ST_WAIT: begin
            if (done) begin
               state_in = msed_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = msed_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      sel_idx   = STG_W'(req_data.stage_sel);
      len_clamp = (int'(req_data.line_length) > MAX_LINE) ? LEN_W'(MAX_LINE)
                                                          : LEN_W'(req_data.line_length);
      dec_clamp = (req_data.decay_factor > msed_pkg::UNITY_Q16) ? msed_pkg::UNITY_Q16
                                                                : req_data.decay_factor;
      line_base = req_data.chan ? LINE_W'(MAX_STAGES) : '0;
      cur_len   = len_ff[stg_ff];
      raw_ptr   = ptr_ff[line_ff];
      cur_ptr   = (LEN_W'(raw_ptr) < cur_len) ? raw_ptr : '0;
      fill      = fill_ff[line_ff];
      hit       = LEN_W'(cur_ptr) < fill;
      ptr_inc   = LEN_W'(cur_ptr) + LEN_W'(1);
      wrap      = ptr_inc >= cur_len;
      zero_len  = (cur_len == '0);
      rd_en     = issue && !zero_len;
      rd_addr   = {line_ff, cur_ptr};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= msed_pkg::ST_IDLE;
         p1_v_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         p1_v_ff  <= issue;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         line_ff <= line_base;
         stg_ff  <= '0;
         last_ff <= last_stage;
      end else if (issue) begin
         line_ff <= line_ff + LINE_W'(1);
         stg_ff  <= stg_ff + STG_W'(1);
      end
      if (issue) begin
         p1_ff      <= '{valid: 1'b1, first: (stg_ff == '0), last: (stg_ff == last_ff),
                         zero_len: zero_len, hit: hit, decay: dec_ff[stg_ff]};
         wr_addr_ff <= rd_addr;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int l = 0; l < LINES; l++) begin
            ptr_ff[l]  <= '0;
            fill_ff[l] <= '0;
         end
         for (int s = 0; s < MAX_STAGES; s++) begin
            len_ff[s] <= '0;
            dec_ff[s] <= '0;
         end
      end else begin
         if (load) begin
            len_ff[sel_idx] <= len_clamp;
            dec_ff[sel_idx] <= dec_clamp;
            for (int c = 0; c < CHANNELS; c++) begin
               for (int s = 0; s < MAX_STAGES; s++) begin
                  if (STG_W'(s) == sel_idx) begin
                     ptr_ff[c * MAX_STAGES + s] <= '0;
                  end
               end
            end
         end
         if (issue && !zero_len) begin
            ptr_ff[line_ff] <= wrap ? '0 : PTR_W'(ptr_inc);
            if (LEN_W'(cur_ptr) == fill) begin
               fill_ff[line_ff] <= ptr_inc;
            end
         end
      end
   end

   always_comb begin
      stage       = p1_ff;
      stage.valid = p1_v_ff;
   end

   assign wr_addr = wr_addr_ff;

endmodule

// File: rtl/msed_dsp.sv
// Datapath: tap select, feed, decay products, accumulate, gains, result register
`timescale 1ns / 1ps
module msed_dsp (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    start,
   input  logic signed [msed_pkg::SAMPLE_BITS-1:0] sample,
   input  logic                                    chan,
   input  msed_pkg::msed_cfg_type                  cfg,
   input  msed_pkg::msed_stage_type                stage,
   input  logic signed [msed_pkg::SAMPLE_BITS-1:0] rd_data,
   output logic                                    wr_en,
   output logic signed [msed_pkg::SAMPLE_BITS-1:0] wr_data,
   output logic                                    done,
   output logic                                    rsp_valid,
   input  logic                                    rsp_stall,
   output msed_pkg::msed_rsp_type                  rsp_data
);

   localparam int SB    = msed_pkg::SAMPLE_BITS;
   localparam int ACC_W = msed_pkg::ACC_W;
   localparam int DRY_W = msed_pkg::DRY_W;
   localparam int SCL_W = msed_pkg::SCL_W;
   localparam int Q_W   = ACC_W - 16;

   localparam logic signed [SB-1:0]    SAMPLE_MAX = {1'b0, {(SB - 1){1'b1}}};
   localparam logic signed [SB-1:0]    SAMPLE_MIN = {1'b1, {(SB - 1){1'b0}}};
   localparam logic signed [ACC_W-1:0] HALF_Q16   = ACC_W'(32768);
   localparam logic signed [Q_W-1:0]   Q_HI       = Q_W'(2 ** (SB - 1) - 1);
   localparam logic signed [Q_W-1:0]   Q_LO       = Q_W'(-(2 ** (SB - 1)));

   function automatic logic signed [SB-1:0] round_sat(input logic signed [ACC_W-1:0] v);
      logic signed [ACC_W-1:0] t;
      logic signed [Q_W-1:0]   q;
      logic signed [SB-1:0]    r;
      t = v + HALF_Q16;
      q = t[ACC_W-1:16];
      if (q > Q_HI) begin
         r = SAMPLE_MAX;
      end else if (q < Q_LO) begin
         r = SAMPLE_MIN;
      end else begin
         r = q[SB-1:0];
      end
      return r;
   endfunction

   logic signed [SB-1:0]     x_ff;
   logic                     chan_ff;
   logic signed [DRY_W-1:0]  dry_ff;
   logic                     init_ff;
   logic signed [SB-1:0]     prev_ff;
   logic signed [SB-1:0]     tap_ff;
   logic [msed_pkg::GAIN_W-1:0] dec_ff;
   logic                     s2_v_ff;
   logic                     s2_last_ff;
   logic signed [DRY_W-1:0]  prod_ff;
   logic                     s3_v_ff;
   logic                     s3_last_ff;
   logic signed [ACC_W-1:0]  acc_ff;
   logic                     acc_v_ff;
   logic signed [SB-1:0]     mix_ff;
   logic                     mix_v_ff;
   logic signed [SCL_W-1:0]  scl_ff;
   logic                     scl_v_ff;
   logic                     rsp_v_ff;
   msed_pkg::msed_rsp_type   rsp_ff;

   logic signed [SB-1:0]     prev;
   logic signed [SB-1:0]     tap;
   logic signed [SB:0]       feed_sum;
   logic signed [SB-1:0]     feed;
   logic signed [SB-1:0]     result;
   logic                     out_load;

   always_comb begin
      prev     = stage.first ? '0 : prev_ff;
      tap      = stage.zero_len ? x_ff : (stage.hit ? rd_data : '0);
      feed_sum = {prev[SB-1], prev} + {x_ff[SB-1], x_ff};
      if (feed_sum[SB] != feed_sum[SB-1]) begin
         feed = feed_sum[SB] ? SAMPLE_MIN : SAMPLE_MAX;
      end else begin
         feed = feed_sum[SB-1:0];
      end
      wr_en    = stage.valid && !stage.zero_len;
      wr_data  = cfg.seq_mode ? feed : x_ff;
      result   = round_sat({{(ACC_W - SCL_W){scl_ff[SCL_W-1]}}, scl_ff});
      out_load = scl_v_ff && (!rsp_v_ff || !rsp_stall);
      done     = out_load;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         init_ff  <= 1'b0;
         s2_v_ff  <= 1'b0;
         s3_v_ff  <= 1'b0;
         acc_v_ff <= 1'b0;
         mix_v_ff <= 1'b0;
         scl_v_ff <= 1'b0;
         rsp_v_ff <= 1'b0;
      end else begin
         init_ff  <= start;
         s2_v_ff  <= stage.valid;
         s3_v_ff  <= s2_v_ff;
         acc_v_ff <= s3_v_ff && s3_last_ff;
         mix_v_ff <= acc_v_ff;
         scl_v_ff <= mix_v_ff || (scl_v_ff && !out_load);
         rsp_v_ff <= out_load || (rsp_v_ff && rsp_stall);
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         x_ff    <= sample;
         chan_ff <= chan;
         dry_ff  <= sample * $signed({1'b0, cfg.in_gain});
      end
      if (stage.valid) begin
         prev_ff    <= tap;
         tap_ff     <= tap;
         dec_ff     <= stage.decay;
         s2_last_ff <= stage.last;
      end
      if (s2_v_ff) begin
         prod_ff    <= tap_ff * $signed({1'b0, dec_ff});
         s3_last_ff <= s2_last_ff;
      end
      if (init_ff) begin
         acc_ff <= {{(ACC_W - DRY_W){dry_ff[DRY_W-1]}}, dry_ff};
      end else if (s3_v_ff) begin
         acc_ff <= acc_ff + {{(ACC_W - DRY_W){prod_ff[DRY_W-1]}}, prod_ff};
      end
      if (acc_v_ff) begin
         mix_ff <= round_sat(acc_ff);
      end
      if (mix_v_ff) begin
         scl_ff <= mix_ff * $signed({1'b0, cfg.out_gain});
      end
      if (out_load) begin
         rsp_ff.out_chan   <= chan_ff;
         rsp_ff.sample_out <= result;
      end
   end

   assign rsp_valid = rsp_v_ff;
   assign rsp_data  = rsp_ff;

endmodule
